// ----- sv/dbbtn_pkg.sv -----
package dbbtn_pkg;

   // Width of the wrapping millisecond time base used for all differences.
   localparam int TIME_BITS = 32;

   localparam int SAMPLE_BITS = 32;
   localparam int CFG_BITS    = 16;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 3;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd200;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

   // Register select bit, taken from paddr[2].
   localparam logic REG_DEBOUNCE   = 1'b0;
   localparam logic REG_LONG_PRESS = 1'b1;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef enum logic {
      EVENT_CLICK = 1'b0,
      EVENT_LONG  = 1'b1
   } event_kind_type;

   typedef logic [TIME_BITS-1:0] time_type;

endpackage

// ----- sv/dbbtn_req_if.sv -----
interface dbbtn_req_if
   import dbbtn_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_time;
   logic                   button_level;

   modport source (output valid, output sample_time, output button_level, input ready);
   modport sink   (input valid, input sample_time, input button_level, output ready);
endinterface

// ----- sv/dbbtn_rsp_if.sv -----
interface dbbtn_rsp_if
   import dbbtn_pkg::*;
();
   logic valid;
   logic ready;
   logic event_kind;

   modport source (output valid, output event_kind, input ready);
   modport sink   (input valid, input event_kind, output ready);
endinterface

// ----- sv/debounced_button_long_press_core.sv -----
// Channel   | Direction | Payload                          | Handshake
// ----------+-----------+----------------------------------+-------------------
// req_chan  | in        | sample_time[31:0], button_level  | valid & ready
// rsp_chan  | out       | event_kind                       | valid & ready
// csr (APB) | in/out    | debounce_time, long_press_time   | psel&penable&pwrite
//
// Each request is evaluated in the cycle it is accepted; its event, if any, sits in
// the output register from the next cycle on. One request per cycle is sustained
// while the sink takes each event; the figure is set by the state update: two
// subtracts and compares on the time registers, feeding the state registers directly.
// A request is refused only while an event waits in the output register and the
// sink is not taking it. Synchronous reset restores the register and state values
// at once; there is no clearing pass.
module debounced_button_long_press_core
   import dbbtn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   dbbtn_req_if.sink            req_chan,
   dbbtn_rsp_if.source          rsp_chan,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   logic [CFG_BITS-1:0] debounce_ff;
   logic [CFG_BITS-1:0] long_press_ff;

   logic     stable_level_ff, stable_level_in;
   logic     held_ff,         held_in;
   logic     long_sent_ff,    long_sent_in;
   time_type change_time_ff,  change_time_in;
   time_type press_start_ff,  press_start_in;

   logic           out_valid_ff;
   event_kind_type out_kind_ff, out_kind_in;
   logic           out_emit;

   logic     accept;
   logic     cfg_write;
   logic [63:0] sample_wide;
   time_type now;
   time_type since_change;
   time_type since_press;
   logic     is_long;

   // ---------------- Configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_DEBOUNCE) begin
            debounce_ff <= pwdata[CFG_BITS-1:0];
         end else begin
            long_press_ff <= pwdata[CFG_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_DEBOUNCE) begin
         prdata = {{(DATA_BITS-CFG_BITS){1'b0}}, debounce_ff};
      end else begin
         prdata = {{(DATA_BITS-CFG_BITS){1'b0}}, long_press_ff};
      end
   end

   // ---------------- Request evaluation ----------------
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign sample_wide  = {{(64-SAMPLE_BITS){1'b0}}, req_chan.sample_time};
   assign now          = sample_wide[TIME_BITS-1:0];
   assign since_change = now - change_time_ff;
   assign since_press  = now - press_start_ff;
   assign is_long      = since_press > {{(TIME_BITS-CFG_BITS){1'b0}}, long_press_ff};

   always_comb begin
      stable_level_in = stable_level_ff;
      held_in         = held_ff;
      long_sent_in    = long_sent_ff;
      change_time_in  = change_time_ff;
      press_start_in  = press_start_ff;
      out_emit        = 1'b0;
      out_kind_in     = EVENT_CLICK;

      if (req_chan.button_level != stable_level_ff) begin
         if (since_change > {{(TIME_BITS-CFG_BITS){1'b0}}, debounce_ff}) begin
            if (req_chan.button_level == LEVEL_PRESSED) begin
               // A fresh press: held is always clear here, so only the start is taken.
               if (!held_ff) begin
                  held_in        = 1'b1;
                  press_start_in = now;
               end else if (is_long && !long_sent_ff) begin
                  long_sent_in = 1'b1;
                  out_emit     = 1'b1;
                  out_kind_in  = EVENT_LONG;
               end
            end else begin
               if (since_press < {{(TIME_BITS-CFG_BITS){1'b0}}, long_press_ff}) begin
                  out_emit    = 1'b1;
                  out_kind_in = EVENT_CLICK;
               end
               held_in      = 1'b0;
               long_sent_in = 1'b0;
            end
            stable_level_in = req_chan.button_level;
            change_time_in  = now;
         end
      end else if (req_chan.button_level == LEVEL_PRESSED) begin
         if (!held_ff) begin
            held_in        = 1'b1;
            press_start_in = now;
         end else if (is_long && !long_sent_ff) begin
            long_sent_in = 1'b1;
            out_emit     = 1'b1;
            out_kind_in  = EVENT_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff <= LEVEL_RELEASED;
         held_ff         <= 1'b0;
         long_sent_ff    <= 1'b0;
         change_time_ff  <= '0;
         press_start_ff  <= '0;
      end else if (accept) begin
         stable_level_ff <= stable_level_in;
         held_ff         <= held_in;
         long_sent_ff    <= long_sent_in;
         change_time_ff  <= change_time_in;
         press_start_ff  <= press_start_in;
      end
   end

   // ---------------- Output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= out_emit;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && out_emit) begin
         out_kind_ff <= out_kind_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.event_kind = out_kind_ff;

`ifndef SYNTH
   // A press is being timed exactly while the debounced level is low.
   a_held_matches_level: assert property (@(posedge clock) disable iff (reset)
      held_ff == !stable_level_ff)
      else $error("held flag disagrees with stable level");

   a_long_needs_held: assert property (@(posedge clock) disable iff (reset)
      long_sent_ff |-> held_ff)
      else $error("long press marked sent without a held button");

   a_long_marks_sent: assert property (@(posedge clock) disable iff (reset)
      (accept && out_emit && out_kind_in == EVENT_LONG) |=> (long_sent_ff && out_valid_ff))
      else $error("long press event not recorded as sent");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while a pending event is stalled");
`endif

endmodule

// ----- tb/sv/debounced_button_long_press_core_test.sv -----
module debounced_button_long_press_core_test;
   import dbbtn_pkg::*;

   localparam int QUIET_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] stamp;
      logic                   level;
   } button_sample_type;

   logic                 clock;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   dbbtn_req_if req_chan ();
   dbbtn_rsp_if rsp_chan ();

   debounced_button_long_press_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Own copy of the button tracker: settings and state.
   logic [CFG_BITS-1:0] debounce_ms    = DEBOUNCE_RESET;
   logic [CFG_BITS-1:0] long_press_ms  = LONG_PRESS_RESET;
   logic                settled_level  = LEVEL_RELEASED;
   logic                press_active   = 1'b0;
   logic                long_reported  = 1'b0;
   time_type            last_change_ms = '0;
   time_type            press_began_ms = '0;

   button_sample_type pending_samples[$];
   event_kind_type    expected_events[$];
   event_kind_type    awaited_event;

   int error_count      = 0;
   int samples_queued   = 0;
   int samples_accepted = 0;
   int events_checked   = 0;
   int settings_applied = 0;
   int hold_off_asked   = 0;
   int hold_off_served  = 0;
   int hold_off_left    = 0;
   int source_gap       = 0;
   int sink_gap         = 0;
   int source_idle_pct  = 20;
   int sink_idle_pct    = 20;
   int quiet_cycles     = 0;
   bit quiet_tail       = 1'b0;

   time_type stamp_cursor;

   // While the stable level is low: begin a press, or report one long press.
   function automatic void track_low(input time_type now);
      time_type held;
      held = now - press_began_ms;
      if (!press_active) begin
         press_active   = 1'b1;
         press_began_ms = now;
      end else if (held > time_type'(long_press_ms) && !long_reported) begin
         long_reported = 1'b1;
         expected_events.push_back(EVENT_LONG);
      end
   endfunction

   function automatic void track_sample(input logic [SAMPLE_BITS-1:0] stamp, input logic level);
      time_type now;
      time_type since_change;
      time_type held;
      now          = time_type'(stamp);
      since_change = now - last_change_ms;
      held         = now - press_began_ms;
      if (level != settled_level) begin
         if (since_change > time_type'(debounce_ms)) begin
            if (level == LEVEL_PRESSED) begin
               track_low(now);
            end else begin
               if (held < time_type'(long_press_ms)) expected_events.push_back(EVENT_CLICK);
               press_active  = 1'b0;
               long_reported = 1'b0;
            end
            settled_level  = level;
            last_change_ms = now;
         end
      end else if (level == LEVEL_PRESSED) begin
         track_low(now);
      end
   endfunction

   function automatic void push_sample(input time_type stamp, input logic level);
      button_sample_type item;
      item.stamp = SAMPLE_BITS'(stamp);
      item.level = level;
      pending_samples.push_back(item);
      samples_queued++;
   endfunction

   // Write a register with junk in the unused upper bits, then read it back.
   task automatic set_register(input logic reg_sel, input logic [CFG_BITS-1:0] value);
      logic [DATA_BITS-CFG_BITS-1:0] upper_junk;
      logic [DATA_BITS-1:0]          readback;
      upper_junk = (DATA_BITS-CFG_BITS)'($urandom);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= {upper_junk, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_sel == REG_DEBOUNCE) debounce_ms = value;
      else long_press_ms = value;
      settings_applied++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== DATA_BITS'(value)) begin
         $error("prdata: expected %0d, actual %0d", value, readback);
         error_count++;
      end
   endtask

   task automatic wait_for_drain();
      while (pending_samples.size() != 0 || expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One press: bounces, an accepted press, samples while held, then the release.
   task automatic add_press_episode();
      int unsigned window;
      int unsigned limit;
      int unsigned hold;
      int unsigned offset;
      time_type    press_at;
      window = debounce_ms;
      limit  = long_press_ms;
      repeat ($urandom_range(0, 3)) begin
         stamp_cursor += $urandom_range(0, window);
         push_sample(stamp_cursor, 1'($urandom_range(0, 1)));
      end
      stamp_cursor += window + $urandom_range(1, 16);
      press_at = stamp_cursor;
      push_sample(press_at, LEVEL_PRESSED);
      case ($urandom_range(0, 3))
         0: hold = limit;
         1: hold = limit + 1;
         default: hold = $urandom_range(0, 2 * limit + 2);
      endcase
      offset = 0;
      repeat ($urandom_range(0, 5)) begin
         offset += $urandom_range(0, hold - offset);
         push_sample(press_at + offset,
                     ($urandom_range(0, 3) == 0) ? LEVEL_RELEASED : LEVEL_PRESSED);
      end
      if ($urandom_range(0, 1) == 1) push_sample(press_at + hold, LEVEL_PRESSED);
      stamp_cursor = press_at + hold + $urandom_range(0, 2);
      push_sample(stamp_cursor, LEVEL_RELEASED);
   endtask

   task automatic add_random_activity(input int count);
      int target;
      target = samples_queued + count;
      while (samples_queued < target) begin
         if ($urandom_range(0, 7) == 0) push_sample($urandom, 1'($urandom_range(0, 1)));
         else add_press_episode();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_chan.valid        = 1'b0;
      req_chan.sample_time  = '0;
      req_chan.button_level = LEVEL_RELEASED;
      rsp_chan.ready        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings after reset: bounce windows, boundaries, wrap of the time base.
      push_sample(32'd0, LEVEL_RELEASED);
      push_sample(32'd100, LEVEL_PRESSED);
      push_sample(32'd200, LEVEL_PRESSED);
      push_sample(32'd201, LEVEL_PRESSED);
      push_sample(32'd1201, LEVEL_PRESSED);
      push_sample(32'd1202, LEVEL_PRESSED);
      push_sample(32'd1300, LEVEL_PRESSED);
      push_sample(32'd1350, LEVEL_RELEASED);
      push_sample(32'd1400, LEVEL_PRESSED);
      push_sample(32'd1600, LEVEL_PRESSED);
      push_sample(32'd1700, LEVEL_RELEASED);
      push_sample(32'd1801, LEVEL_RELEASED);
      push_sample(32'd3000, LEVEL_PRESSED);
      push_sample(32'd4000, LEVEL_RELEASED);
      push_sample(32'hFFFF_FF00, LEVEL_PRESSED);
      push_sample(32'h0000_0100, LEVEL_RELEASED);
      push_sample(32'h0000_1000, LEVEL_PRESSED);
      push_sample(32'h0000_13E9, LEVEL_PRESSED);
      push_sample(32'h0000_11F4, LEVEL_RELEASED);
      push_sample(32'hFFFF_FFFF, LEVEL_RELEASED);
      stamp_cursor = $urandom;
      add_random_activity(60);
      wait_for_drain();

      // Both limits at zero.
      set_register(REG_DEBOUNCE, 16'd0);
      set_register(REG_LONG_PRESS, 16'd0);
      stamp_cursor += 32'd70000;
      push_sample(stamp_cursor, LEVEL_PRESSED);
      push_sample(stamp_cursor, LEVEL_PRESSED);
      push_sample(stamp_cursor + 1, LEVEL_PRESSED);
      push_sample(stamp_cursor + 1, LEVEL_RELEASED);
      push_sample(stamp_cursor + 2, LEVEL_RELEASED);
      stamp_cursor += 2;
      add_random_activity(60);
      wait_for_drain();

      // Both limits at their maximum.
      set_register(REG_DEBOUNCE, 16'hFFFF);
      set_register(REG_LONG_PRESS, 16'hFFFF);
      stamp_cursor += 32'd70000;
      push_sample(stamp_cursor, LEVEL_PRESSED);
      push_sample(stamp_cursor + 32'd65535, LEVEL_PRESSED);
      push_sample(stamp_cursor + 32'd65536, LEVEL_PRESSED);
      push_sample(stamp_cursor + 32'd65537, LEVEL_RELEASED);
      stamp_cursor += 32'd65537;
      add_random_activity(50);
      wait_for_drain();

      // Every release gives a click while the sink holds off, so the block stalls.
      set_register(REG_DEBOUNCE, 16'd0);
      stamp_cursor += 32'd70000;
      hold_off_asked++;
      for (int n = 0; n < 40; n++) begin
         stamp_cursor += 1;
         push_sample(stamp_cursor, (n % 2 == 0) ? LEVEL_PRESSED : LEVEL_RELEASED);
      end
      wait_for_drain();

      set_register(REG_DEBOUNCE, 16'($urandom));
      set_register(REG_LONG_PRESS, 16'($urandom));
      stamp_cursor += 32'd70000;
      add_random_activity(140);
      wait_for_drain();

      // Short limits and no idling on either side to close the run.
      set_register(REG_DEBOUNCE, 16'd5);
      set_register(REG_LONG_PRESS, 16'd30);
      quiet_tail = 1'b1;
      stamp_cursor += 32'd70000;
      add_random_activity(70);
      wait_for_drain();

      if (expected_events.size() != 0) begin
         $error("%0d expected events never arrived", expected_events.size());
         error_count++;
      end
      $display("Drove %0d button samples and checked %0d events over %0d register writes,",
               samples_accepted, events_checked, settings_applied);
      $display("with bounces, boundary holds, time wrap and a long stall at the output.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Request driver: the head of the pending queue is offered until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         source_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            track_sample(req_chan.sample_time, req_chan.button_level);
            void'(pending_samples.pop_front());
            samples_accepted++;
         end
         if ($urandom_range(0, 63) == 0) source_idle_pct = $urandom_range(0, 3) * 10;
         if (req_chan.valid && !req_chan.ready) begin
            // The request on offer stays in place until it is taken.
         end else if (source_gap > 0) begin
            source_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_samples.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < source_idle_pct) begin
            source_gap = $urandom_range(0, 7);
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid        <= 1'b1;
            req_chan.sample_time  <= pending_samples[0].stamp;
            req_chan.button_level <= pending_samples[0].level;
         end
      end
   end

   // Event monitor and sink readiness.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_events.size() == 0) begin
               $error("event_kind: expected no event, actual %0d", rsp_chan.event_kind);
               error_count++;
            end else begin
               awaited_event = expected_events.pop_front();
               if (rsp_chan.event_kind !== awaited_event) begin
                  $error("event_kind: expected %0d, actual %0d", awaited_event,
                         rsp_chan.event_kind);
                  error_count++;
               end
               events_checked++;
            end
         end
         if (hold_off_served != hold_off_asked) begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if ($urandom_range(0, 63) == 0) sink_idle_pct = $urandom_range(0, 3) * 10;
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

// ----- files.f -----
sv/dbbtn_pkg.sv
sv/dbbtn_req_if.sv
sv/dbbtn_rsp_if.sv
sv/debounced_button_long_press_core.sv
tb/sv/debounced_button_long_press_core_test.sv
